>>> rtl/lzb_pkg.sv
// Shared types and constants for the byte-token LZ decompressor.
// No dependencies; imported by every module of the block.
package lzb_pkg;

  // History ring geometry
  localparam int unsigned HIST_DEPTH = 256;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Token decoding
  localparam logic [7:0] LIT_BOUND  = 8'h80;
  localparam logic [8:0] TOKEN_BASE = 9'h100;

  // Output limit after reset
  localparam logic [15:0] LIMIT_RESET = 16'd4096;

  // Output tdata width: byte_a, byte_b, lanes, status, total_len, padded to bytes
  localparam int unsigned OUT_BITS  = 8 + 8 + 2 + 2 + 16;
  localparam int unsigned OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  // Sticky stream status
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_LIMIT    = 2'd1,
    STAT_BAD_DIST = 2'd2,
    STAT_TRUNC    = 2'd3
  } status_e;

  // One byte (or an empty closing entry) handed from sequencer to packer
  typedef struct packed {
    logic        valid;
    logic        has_byte;
    logic [7:0]  data;
    logic        final_byte;
    logic        stream_end;
    status_e     status;
    logic [15:0] total_len;
  } lzb_push_t;

endpackage

>>> rtl/lzb_hist_mem.sv
// History ring memory: one write port, one registered read port.
// Depends on lzb_pkg for depth and address width.
module lzb_hist_mem
  import lzb_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [HIST_AW-1:0] waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic               re_i,
  input  logic [HIST_AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [HIST_DEPTH];
  logic [7:0] rdata_q;

  // Write-first: a read of the address being written returns the new byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lzb_packer.sv
// Pairs decompressed bytes into two-lane results and holds the output register.
// Depends on lzb_pkg for the push struct and status type.
module lzb_packer
  import lzb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lzb_push_t            push_i,
  output logic                 push_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_TDATA-1:0] out_data_o,
  output logic                 out_last_o,
  output logic                 out_end_o
);

  logic        out_valid_q, out_valid_d;
  logic        has_a_q, has_a_d;
  logic [7:0]  a_q;
  logic [7:0]  byte_a_q, byte_b_q;
  logic [1:0]  lanes_q;
  status_e     status_q;
  logic [15:0] total_q;
  logic        run_last_q, end_q;
  logic        hold_first;
  logic        take;

  // First byte of a pair is parked; anything else produces a result
  assign hold_first   = push_i.has_byte && !has_a_q && !push_i.final_byte;
  assign push_ready_o = hold_first || !out_valid_q || out_ready_i;
  assign take         = push_i.valid && push_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    has_a_d     = has_a_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      if (hold_first) begin
        has_a_d = 1'b1;
      end else begin
        has_a_d     = 1'b0;
        out_valid_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      has_a_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      has_a_q     <= has_a_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take && hold_first) begin
      a_q <= push_i.data;
    end
    if (take && !hold_first) begin
      if (has_a_q) begin
        byte_a_q <= a_q;
        byte_b_q <= push_i.has_byte ? push_i.data : 8'd0;
        lanes_q  <= push_i.has_byte ? 2'd2 : 2'd1;
      end else begin
        byte_a_q <= push_i.has_byte ? push_i.data : 8'd0;
        byte_b_q <= 8'd0;
        lanes_q  <= push_i.has_byte ? 2'd1 : 2'd0;
      end
      status_q   <= push_i.status;
      total_q    <= push_i.total_len;
      run_last_q <= push_i.final_byte;
      end_q      <= push_i.stream_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = run_last_q;
  assign out_end_o   = end_q;
  assign out_data_o  = {(OUT_TDATA - OUT_BITS)'(0), total_q, status_q, lanes_q,
                        byte_b_q, byte_a_q};

endmodule

>>> rtl/lzb_ctrl.sv
// Sequencer: decodes literal/token/distance bytes and runs the match copy loop.
// Depends on lzb_pkg; drives lzb_hist_mem and lzb_packer.
module lzb_ctrl
  import lzb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output logic               mem_we_o,
  output logic [HIST_AW-1:0] mem_waddr_o,
  output logic [7:0]         mem_wdata_o,
  output logic               mem_re_o,
  output logic [HIST_AW-1:0] mem_raddr_o,
  input  logic [7:0]         mem_rdata_i,
  output lzb_push_t          push_o,
  input  logic               push_ready_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT,
    ST_CLOSE
  } state_e;

  state_e             state_q, state_d;
  logic               pending_q, pending_d;
  logic [7:0]         plen_q, plen_d;
  logic [15:0]        prod_q, prod_d;
  status_e            status_q, status_d;
  logic [15:0]        limit_q, limit_d;
  logic [7:0]         cnt_q, cnt_d;
  logic               src_lit_q, src_lit_d;
  logic               last_q;
  logic [7:0]         byte_q;
  logic [HIST_AW-1:0] rptr_q, rptr_d;

  logic               accept;
  logic               is_lit;
  logic               bad_dist;
  logic [15:0]        need;
  logic [15:0]        room;
  logic [7:0]         dec_n;
  logic               reach;
  status_e            fault;
  logic [7:0]         emit_n;
  logic [7:0]         cur_byte;
  logic               final_byte;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Decode arithmetic: room left under the limit and bytes to emit
  assign is_lit   = (byte_q < LIT_BOUND);
  assign bad_dist = (byte_q == 8'd0) || ({8'd0, byte_q} > prod_q) ||
                    (32'(byte_q) > HIST_DEPTH);
  assign need     = pending_q ? {8'd0, plen_q} : 16'd1;
  assign room     = (prod_q < limit_q) ? (limit_q - prod_q) : 16'd0;
  assign dec_n    = (room < need) ? room[7:0] : need[7:0];
  assign reach    = ({1'b0, prod_q} + {1'b0, need}) >= {1'b0, limit_q};

  always_comb begin
    fault  = STAT_OK;
    emit_n = 8'd0;
    priority if (pending_q) begin
      if (bad_dist) begin
        fault = STAT_BAD_DIST;
      end else begin
        fault  = reach ? STAT_LIMIT : STAT_OK;
        emit_n = dec_n;
      end
    end else if (is_lit) begin
      fault  = reach ? STAT_LIMIT : STAT_OK;
      emit_n = dec_n;
    end else if (last_q) begin
      fault = STAT_TRUNC;
    end else begin
      fault = STAT_OK;
    end
  end

  assign cur_byte   = src_lit_q ? byte_q : mem_rdata_i;
  assign final_byte = (cnt_q == 8'd1);

  // Next state, memory and packer control
  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    plen_d    = plen_q;
    prod_d    = prod_q;
    status_d  = status_q;
    limit_d   = cfg_we_i ? cfg_wdata_i : limit_q;
    cnt_d     = cnt_q;
    src_lit_d = src_lit_q;
    rptr_d    = rptr_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = prod_q[HIST_AW-1:0];
    mem_wdata_o = cur_byte;
    mem_re_o    = 1'b0;
    mem_raddr_o = rptr_q + HIST_AW'(1);

    push_o            = '0;
    push_o.status     = status_q;
    push_o.total_len  = prod_q;
    push_o.data       = cur_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_q == STAT_OK) begin
          status_d = fault;
        end
        cnt_d     = emit_n;
        src_lit_d = !pending_q;
        if (pending_q) begin
          pending_d = 1'b0;
          plen_d    = 8'd0;
        end else if (!is_lit && !last_q) begin
          pending_d = 1'b1;
          plen_d    = 8'(TOKEN_BASE - {1'b0, byte_q});
        end
        if (emit_n != 8'd0) begin
          state_d = ST_EMIT;
          if (pending_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = prod_q[HIST_AW-1:0] - HIST_AW'(byte_q);
            rptr_d      = mem_raddr_o;
          end
        end else if (last_q) begin
          state_d = ST_CLOSE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        push_o.valid      = 1'b1;
        push_o.has_byte   = 1'b1;
        push_o.final_byte = final_byte;
        push_o.stream_end = final_byte && last_q;
        push_o.total_len  = prod_q + 16'd1;
        if (push_ready_i) begin
          mem_we_o = 1'b1;
          prod_d   = prod_q + 16'd1;
          cnt_d    = cnt_q - 8'd1;
          // Overlapped copy: next read may hit the byte written now
          if (!final_byte && !src_lit_q) begin
            mem_re_o = 1'b1;
            rptr_d   = mem_raddr_o;
          end
          if (final_byte) begin
            state_d = ST_IDLE;
            if (last_q) begin
              prod_d    = 16'd0;
              pending_d = 1'b0;
              plen_d    = 8'd0;
              status_d  = STAT_OK;
            end
          end
        end
      end
      ST_CLOSE: begin
        push_o.valid      = 1'b1;
        push_o.final_byte = 1'b1;
        push_o.stream_end = 1'b1;
        if (push_ready_i) begin
          state_d   = ST_IDLE;
          prod_d    = 16'd0;
          pending_d = 1'b0;
          plen_d    = 8'd0;
          status_d  = STAT_OK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and stream bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= 1'b0;
      plen_q    <= 8'd0;
      prod_q    <= 16'd0;
      status_q  <= STAT_OK;
      limit_q   <= LIMIT_RESET;
      cnt_q     <= 8'd0;
      src_lit_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      plen_q    <= plen_d;
      prod_q    <= prod_d;
      status_q  <= status_d;
      limit_q   <= limit_d;
      cnt_q     <= cnt_d;
      src_lit_q <= src_lit_d;
    end
  end

  // Input capture and read pointer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    rptr_q <= rptr_d;
  end

`ifndef SYNTHESIS
  // A history write only happens below the output limit
  a_write_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (prod_q < limit_q))
    else $error("history write at or above output limit");

  // The copy loop never runs with an exhausted count
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != 8'd0))
    else $error("emit state with zero byte count");

  // Closing the stream leaves the bookkeeping cleared
  a_stream_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_ready_i && push_o.stream_end) |=>
      (!pending_q && (prod_q == 16'd0) && (status_q == STAT_OK)))
    else $error("stream state not cleared after stream end");

  // A stored match length is always one to 128
  a_plen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> ((plen_q != 8'd0) && (plen_q <= 8'd128)))
    else $error("pending match length out of range");
`endif

endmodule

>>> rtl/lz_byte_token_decompressor.sv
// Top level of the byte-token LZ decompressor: stream ports and config register.
// Depends on lzb_pkg, lzb_ctrl, lzb_hist_mem and lzb_packer.
//
// One compressed byte per input transaction. A literal (below 0x80) is accepted,
// decoded and then emitted. A match token is accepted and decoded and produces
// nothing; its distance byte is accepted and decoded, then the copy loop reads
// and writes the 256-byte history RAM one byte per cycle while the output is not
// stalled. Bytes leave in pairs, so a match yields one result per two bytes. A
// final byte that emits nothing is followed by an empty closing result. Output
// backpressure stalls the copy loop; a finished result waits in the output
// register while the next input transaction is accepted. output_limit is written
// through cfg_we_i/cfg_wdata_i and must only change while the block is idle. No
// clearing pass after reset.
module lz_byte_token_decompressor
  import lzb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: output_limit
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  // Compressed input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] in_byte
  input  logic                 s_axis_tlast,  // in_last
  // Decompressed output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] byte_a, [15:8] byte_b, [17:16] lanes, [19:18] status,
  // [35:20] total_len, upper bits zero
  output logic [OUT_TDATA-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,  // run_last
  output logic                 m_axis_tuser   // [0] stream_end
);

  logic               mem_we;
  logic [HIST_AW-1:0] mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [HIST_AW-1:0] mem_raddr;
  logic [7:0]         mem_rdata;
  lzb_push_t          push;
  logic               push_ready;

  // Sequencer
  lzb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // History ring
  lzb_hist_mem u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Byte pairing and output register
  lzb_packer u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_end_o    (m_axis_tuser)
  );

endmodule
